>>> sv/scfa_pkg.sv
// ----------------------------------------------------------------------------
// scfa_pkg: shared definitions for the size class free list allocator
// Widths, request and status codes, controller types and the class lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package scfa_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int NUM_CLASSES = 10;
    localparam int ADDR_SPACE  = 65536;

    localparam int LEN_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 17;
    localparam int SLOT_W   = 12;
    localparam int SLOT_DEPTH = 1 << SLOT_W;
    localparam int LINK_W   = SLOT_W + 1;
    localparam int TAG_W    = 4;
    localparam int CLS_W    = 4;
    localparam int NEED_W   = LEN_W + 1;
    localparam int MIN_CHUNK_LOG = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Largest chunk and the byte limit that the bump pointer can never pass.
    localparam logic [NEED_W-1:0] MAX_CHUNK = NEED_W'(16 << (NUM_CLASSES - 1));
    localparam int HEAP_CAP_I = (HEAP_BYTES < ADDR_SPACE) ? HEAP_BYTES : ADDR_SPACE;
    localparam logic [CFG_W-1:0] HEAP_CAP = CFG_W'(HEAP_CAP_I);
    localparam logic [CFG_W-1:0] HEAP_SIZE_RESET = CFG_W'(65536);

    // Register index of the configuration port.
    localparam logic REG_HEAP_SIZE = 1'b0;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Smallest class whose chunk holds need bytes; the top class if none does.
    function automatic logic [CLS_W-1:0] class_of(input logic [NEED_W-1:0] need);
        logic [CLS_W-1:0] cls;
        cls = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (need <= (NEED_W'(16) << i))
            begin
                cls = CLS_W'(i);
            end
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> sv/scfa_ram.sv
// ----------------------------------------------------------------------------
// scfa_ram: generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/scfa_ctrl.sv
// ----------------------------------------------------------------------------
// scfa_ctrl: request sequencer
// Accepts a request, runs its execute cycle and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scfa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output scfa_pkg::ctrl_cmd_t cmd
);

    scfa_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // The result register is free for a new item once it is empty or drained.
    assign in_ready  = (state_reg == scfa_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            scfa_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = scfa_pkg::ST_EXEC;
                end
            end
            scfa_pkg::ST_EXEC:
            begin
                cmd.execute    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = scfa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = scfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scfa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/scfa_datapath.sv
// ----------------------------------------------------------------------------
// scfa_datapath: class heads, bump pointer, link and tag memories
// Decodes a request on capture and applies it on the execute cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scfa_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire scfa_pkg::ctrl_cmd_t             cmd,
    input  wire logic                            req_type,
    input  wire logic [scfa_pkg::LEN_W-1:0]      request_length,
    input  wire logic [scfa_pkg::ADDR_W-1:0]     free_address,
    input  wire logic [scfa_pkg::CFG_W-1:0]      heap_size,
    output logic      [scfa_pkg::ADDR_W-1:0]     result_address,
    output logic      [scfa_pkg::STATUS_W-1:0]   status
);

    localparam int SW = scfa_pkg::SLOT_W;
    localparam int LW = scfa_pkg::LINK_W;
    localparam int CW = scfa_pkg::CLS_W;

    logic [LW-1:0] heads_reg [scfa_pkg::NUM_CLASSES];
    logic [scfa_pkg::CFG_W-1:0] bump_reg;

    logic          req_reg;
    logic          too_large_reg;
    logic          head_hit_reg;
    logic          free_ok_reg;
    logic [CW-1:0] cls_reg;
    logic [SW-1:0] slot_reg;
    logic [scfa_pkg::ADDR_W-1:0]   res_addr_reg;
    logic [scfa_pkg::STATUS_W-1:0] res_status_reg;

    // Capture-cycle decode.
    logic [scfa_pkg::NEED_W-1:0] need;
    logic [CW-1:0]               cls_in;
    logic [LW-1:0]               head_in;
    logic [scfa_pkg::ADDR_W-1:0] free_off;
    logic                        free_ok_in;

    assign need       = scfa_pkg::NEED_W'(request_length) + scfa_pkg::NEED_W'(1);
    assign cls_in     = scfa_pkg::class_of(need);
    assign head_in    = heads_reg[cls_in];
    assign free_off   = free_address - scfa_pkg::ADDR_W'(1);
    assign free_ok_in = (free_address != '0) && (free_off[3:0] == 4'd0);

    // Memories.
    logic          link_we, tag_we;
    logic [LW-1:0] link_wdata, link_rdata;
    logic [scfa_pkg::TAG_W-1:0] tag_rdata;

    scfa_ram #(.WIDTH(LW), .DEPTH(scfa_pkg::SLOT_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (slot_reg),
        .wdata (link_wdata),
        .raddr (head_in[SW-1:0]),
        .rdata (link_rdata)
    );

    scfa_ram #(.WIDTH(scfa_pkg::TAG_W), .DEPTH(scfa_pkg::SLOT_DEPTH)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (slot_reg),
        .wdata (scfa_pkg::TAG_W'(cls_reg)),
        .raddr (free_off[SW+3:4]),
        .rdata (tag_rdata)
    );

    // Execute-cycle logic.
    logic [CW-1:0]              free_cls;
    logic [scfa_pkg::CFG_W-1:0] chunk_size;
    logic [scfa_pkg::CFG_W-1:0] limit;
    logic [scfa_pkg::CFG_W-1:0] room;
    logic                       bump_fail;

    // A tag beyond the class range only comes from a never-written slot.
    assign free_cls   = (tag_rdata >= scfa_pkg::TAG_W'(scfa_pkg::NUM_CLASSES)) ?
                        '0 : CW'(tag_rdata);
    assign chunk_size = scfa_pkg::CFG_W'(16) << cls_reg;
    assign limit      = (heap_size < scfa_pkg::HEAP_CAP) ? heap_size : scfa_pkg::HEAP_CAP;
    assign room       = (limit > bump_reg) ? (limit - bump_reg) : '0;
    assign bump_fail  = (room <= chunk_size);

    always_comb
    begin
        link_we    = cmd.execute && (req_reg == scfa_pkg::REQ_FREE) && free_ok_reg;
        link_wdata = heads_reg[free_cls];
        tag_we     = cmd.execute && (req_reg == scfa_pkg::REQ_ALLOC) && !too_large_reg &&
                     (head_hit_reg || !bump_fail);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scfa_pkg::NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
            bump_reg <= '0;
        end
        else if (cmd.execute)
        begin
            if (req_reg == scfa_pkg::REQ_FREE)
            begin
                if (free_ok_reg)
                begin
                    heads_reg[free_cls] <= {1'b1, slot_reg};
                end
            end
            else if (!too_large_reg)
            begin
                if (head_hit_reg)
                begin
                    heads_reg[cls_reg] <= link_rdata;
                end
                else if (!bump_fail)
                begin
                    bump_reg <= bump_reg + chunk_size;
                end
            end
        end
    end

    // Slot and the result are payload and need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg       <= req_type;
            too_large_reg <= (need > scfa_pkg::MAX_CHUNK);
            cls_reg       <= cls_in;
            head_hit_reg  <= head_in[LW-1];
            free_ok_reg   <= free_ok_in;
            if (req_type == scfa_pkg::REQ_FREE)
            begin
                slot_reg <= free_off[SW+3:4];
            end
            else if (head_in[LW-1])
            begin
                slot_reg <= head_in[SW-1:0];
            end
            else
            begin
                // Bump allocation: the pointer only moves on execute, so its
                // slot is already settled here.
                slot_reg <= bump_reg[SW+3:4];
            end
        end

        if (cmd.execute)
        begin
            if (req_reg != scfa_pkg::REQ_ALLOC)
            begin
                res_addr_reg   <= '0;
                res_status_reg <= scfa_pkg::STATUS_OK;
            end
            else if (too_large_reg)
            begin
                res_addr_reg   <= '0;
                res_status_reg <= scfa_pkg::STATUS_TOO_LARGE;
            end
            else if (!head_hit_reg && bump_fail)
            begin
                res_addr_reg   <= '0;
                res_status_reg <= scfa_pkg::STATUS_NO_SPACE;
            end
            else
            begin
                res_addr_reg   <= {slot_reg, 4'd1};
                res_status_reg <= scfa_pkg::STATUS_OK;
            end
        end
    end

    assign result_address = res_addr_reg;
    assign status         = res_status_reg;

endmodule

`default_nettype wire

>>> sv/size_class_free_list_allocator.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator: power-of-two segregated fit allocator
// Serves allocate and free requests over a 64 KiB heap with LIFO class lists.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_* stream: s_tuser is the kind (0 allocate,
//   1 free), s_tdata carries the length and the address to free. Every
//   request gives exactly one result word on the m_* stream: the chunk
//   address (offset plus one) and a status code.
//   A request runs through an accept cycle and an execute cycle: the accept
//   cycle decodes the class, reads the class head and issues the synchronous
//   read of the link or tag memory; the execute cycle uses that read data to
//   update the head, the bump pointer and the memories, and loads the result
//   register. m_tvalid rises at the edge that ends the execute cycle. The
//   link and tag memory read ports make the execute cycle needed; no new
//   request is taken before the last one has finished its execute cycle.
//   A new request is taken only while the result register is empty or is
//   drained at the same edge; a stalled receiver holds the result and
//   blocks further requests until it takes the word.
//   Reset empties all class lists and clears the bump pointer; no clearing pass
//   runs, as the link memory is only read after a write. The user writes heap_size
//   through the APB port at address 0 only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_free_list_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] request_length, [31:16] free_address
    input  wire logic        s_tuser,   // [0] req_type
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [15:0] result_address, [17:16] status, rest zero
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [scfa_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [scfa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [scfa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    scfa_pkg::ctrl_cmd_t cmd;

    logic [scfa_pkg::CFG_W-1:0]    heap_size_reg;
    logic [scfa_pkg::ADDR_W-1:0]   result_address;
    logic [scfa_pkg::STATUS_W-1:0] status;
    logic                          reg_index;

    // Register index is the word address; anything beyond the list is ignored.
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= scfa_pkg::HEAP_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (reg_index == scfa_pkg::REG_HEAP_SIZE))
        begin
            heap_size_reg <= pwdata[scfa_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            scfa_pkg::REG_HEAP_SIZE: prdata = scfa_pkg::APB_DATA_W'(heap_size_reg);
            default:                 prdata = '0;
        endcase
    end

    // The controller sequences each request through capture and execute.
    scfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    scfa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req_type       (s_tuser),
        .request_length (s_tdata[15:0]),
        .free_address   (s_tdata[31:16]),
        .heap_size      (heap_size_reg),
        .result_address (result_address),
        .status         (status)
    );

    assign m_tdata = {6'd0, status, result_address};

`ifndef NO_ASSERTIONS
    // An accepted request keeps the input closed during its execute cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted during execute cycle");

    // Every accepted request yields a result once its execute cycle has ended.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result missing after request");

    // A free never returns an address.
    a_free_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |-> ##2 (m_tdata[15:0] == 16'd0))
        else $error("free returned a nonzero address");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
